[design/ntc_pkg.sv]
`default_nettype none
package ntc_pkg;

    localparam int ValueWidth = 64;
    localparam int TypeWidth  = 3;

    typedef enum logic [2:0] {
        TYPE_I32 = 3'd0,
        TYPE_I64 = 3'd1,
        TYPE_F32 = 3'd2,
        TYPE_F64 = 3'd3
    } num_type_t;

    // Position of the highest set bit; zero for a zero input.
    function automatic logic [5:0] top_bit(input logic [63:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

[design/numeric_type_converter_unit.sv]
`default_nettype none
// Numeric type converter between int32, int64, float32 and float64.
// Input stream: s_axis_tdata carries value_bits; s_axis_tuser carries
// src_type (bits 2:0) and dst_type (bits 5:3). Output stream: m_axis_tdata
// carries result_bits; m_axis_tuser carries ok (bit 0) and invalid (bit 1).
// Every request passes three register stages: decode, leading-one and
// alignment shift, then rounding and packing. One request is accepted every
// cycle while the receiver takes results without stalling.
// The pipeline advances as one unit: it moves whenever its last stage is
// empty or being taken, so a receiver that stalls holds all stages in place
// and s_axis_tready falls; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears the stage valid bits; payload
// registers are left as they are.
module numeric_type_converter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // value_bits[63:0]
    input  wire logic [63:0] s_axis_tdata,
    // src_type[2:0], dst_type[5:3]
    input  wire logic [5:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_bits[63:0]
    output logic [63:0]      m_axis_tdata,
    // ok[0], invalid[1]
    output logic [1:0]       m_axis_tuser
);

    logic        en;
    logic        out_valid, out_ok, out_invalid;
    logic [63:0] out_result;

    // Whole pipeline steps when the output slot is free or being taken.
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    ntc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .in_value    (s_axis_tdata),
        .in_src      (s_axis_tuser[2:0]),
        .in_dst      (s_axis_tuser[5:3]),
        .out_valid   (out_valid),
        .out_result  (out_result),
        .out_ok      (out_ok),
        .out_invalid (out_invalid)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = out_result;
    assign m_axis_tuser  = {out_invalid, out_ok};

    // A stalled output holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // A refused conversion never raises invalid and gives zero bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata == 64'd0)
        else $error("refused conversion carries data");

    // Input is taken exactly when the pipeline advances; an empty output never stalls it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");

endmodule
`default_nettype wire

[design/ntc_core.sv]
`default_nettype none
// Three-stage conversion datapath with a valid bit per stage and a global enable.
module ntc_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_value,
    input  wire logic [2:0]  in_src,
    input  wire logic [2:0]  in_dst,
    output logic             out_valid,
    output logic [63:0]      out_result,
    output logic             out_ok,
    output logic             out_invalid
);

    // Operation class decided in stage one.
    typedef enum logic [2:0] {
        OP_DIRECT,
        OP_I2F,
        OP_F2I,
        OP_F2F64,
        OP_F2F32
    } op_t;

    // ---------------- Stage 1: decode and unpack ----------------
    logic        v1_reg;
    op_t         op1_reg;
    logic [63:0] direct1_reg;
    logic        ok1_reg;
    logic        sign1_reg;
    logic [63:0] mag1_reg;
    logic        dst32_1_reg;
    logic        is_nan1_reg, is_inf1_reg, is_zero1_reg;
    logic signed [12:0] exp1_reg;
    logic [63:0] sig1_reg;

    op_t         op1_next;
    logic [63:0] direct1_next, mag1_next, sig1_next, x_ext;
    logic        ok1_next, sign1_next, nan1_next, inf1_next, zero1_next;
    logic signed [12:0] exp1_next;

    always_comb begin
        op1_next     = OP_DIRECT;
        direct1_next = 64'd0;
        ok1_next     = 1'b1;
        sign1_next   = 1'b0;
        mag1_next    = 64'd0;
        sig1_next    = 64'd0;
        exp1_next    = 13'sd0;
        nan1_next    = 1'b0;
        inf1_next    = 1'b0;
        zero1_next   = 1'b0;
        x_ext        = (in_src == 3'(ntc_pkg::TYPE_I32))
                     ? {{32{in_value[31]}}, in_value[31:0]} : in_value;
        if (in_src > 3'(ntc_pkg::TYPE_F64) || in_dst > 3'(ntc_pkg::TYPE_F64)) begin
            ok1_next = 1'b0;
        end else if (in_src == in_dst) begin
            direct1_next = (in_src == 3'(ntc_pkg::TYPE_I32) || in_src == 3'(ntc_pkg::TYPE_F32))
                         ? {32'd0, in_value[31:0]} : in_value;
        end else if (in_src == 3'(ntc_pkg::TYPE_I32) || in_src == 3'(ntc_pkg::TYPE_I64)) begin
            if (in_dst == 3'(ntc_pkg::TYPE_I32)) begin
                direct1_next = {32'd0, x_ext[31:0]};
            end else if (in_dst == 3'(ntc_pkg::TYPE_I64)) begin
                direct1_next = x_ext;
            end else begin
                op1_next   = OP_I2F;
                sign1_next = x_ext[63];
                mag1_next  = x_ext[63] ? (64'd0 - x_ext) : x_ext;
            end
        end else if (in_src == 3'(ntc_pkg::TYPE_F32)) begin
            sign1_next = in_value[31];
            nan1_next  = (in_value[30:23] == 8'hFF) && (in_value[22:0] != 23'd0);
            inf1_next  = (in_value[30:23] == 8'hFF) && (in_value[22:0] == 23'd0);
            zero1_next = (in_value[30:23] == 8'd0);
            // Significand with its point after bit 52, exponent unbiased.
            sig1_next  = {11'd0, (in_value[30:23] != 8'd0), in_value[22:0], 29'd0};
            exp1_next  = 13'(signed'({5'd0, in_value[30:23]})) - 13'sd127;
            mag1_next  = {41'd0, in_value[22:0]};
            op1_next   = (in_dst == 3'(ntc_pkg::TYPE_F64)) ? OP_F2F64 : OP_F2I;
        end else begin
            sign1_next = in_value[63];
            nan1_next  = (in_value[62:52] == 11'h7FF) && (in_value[51:0] != 52'd0);
            inf1_next  = (in_value[62:52] == 11'h7FF) && (in_value[51:0] == 52'd0);
            zero1_next = (in_value[62:52] == 11'd0);
            sig1_next  = {11'd0, 1'b1, in_value[51:0]};
            exp1_next  = 13'(signed'({2'd0, in_value[62:52]})) - 13'sd1023;
            mag1_next  = in_value;
            op1_next   = (in_dst == 3'(ntc_pkg::TYPE_F32)) ? OP_F2F32 : OP_F2I;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg      <= op1_next;
            direct1_reg  <= direct1_next;
            ok1_reg      <= ok1_next;
            sign1_reg    <= sign1_next;
            mag1_reg     <= mag1_next;
            sig1_reg     <= sig1_next;
            exp1_reg     <= exp1_next;
            is_nan1_reg  <= nan1_next;
            is_inf1_reg  <= inf1_next;
            is_zero1_reg <= zero1_next;
            dst32_1_reg  <= (in_dst == 3'(ntc_pkg::TYPE_I32) || in_dst == 3'(ntc_pkg::TYPE_F32));
        end
    end

    // ---------------- Stage 2: leading one and alignment shift ----------------
    logic        v2_reg;
    op_t         op2_reg;
    logic [63:0] direct2_reg;
    logic        ok2_reg, sign2_reg, dst32_2_reg, nan2_reg, inf2_reg, zero2_reg;
    logic [63:0] mag2_reg;   // normalized: leading one at bit 63
    logic [5:0]  p2_reg;
    logic signed [12:0] exp2_reg;
    logic [63:0] sig2_reg;
    logic [63:0] int2_reg;   // truncated float-to-int magnitude
    logic        big2_reg;   // exponent at or beyond 64

    logic [5:0]  p2_next;
    logic [63:0] int2_next;
    logic        big2_next;

    always_comb begin
        p2_next   = ntc_pkg::top_bit(mag1_reg);
        int2_next = 64'd0;
        big2_next = 1'b0;
        if (exp1_reg >= 13'sd64) begin
            big2_next = 1'b1;
        end else if (exp1_reg >= 13'sd52) begin
            int2_next = sig1_reg << 6'(exp1_reg - 13'sd52);
        end else if (exp1_reg >= 13'sd0) begin
            int2_next = sig1_reg >> 6'(13'sd52 - exp1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg     <= op1_reg;
            direct2_reg <= direct1_reg;
            ok2_reg     <= ok1_reg;
            sign2_reg   <= sign1_reg;
            dst32_2_reg <= dst32_1_reg;
            nan2_reg    <= is_nan1_reg;
            inf2_reg    <= is_inf1_reg;
            zero2_reg   <= is_zero1_reg;
            mag2_reg    <= mag1_reg << (6'd63 - p2_next);
            p2_reg      <= p2_next;
            exp2_reg    <= exp1_reg;
            sig2_reg    <= sig1_reg;
            int2_reg    <= int2_next;
            big2_reg    <= big2_next;
        end
    end

    // ---------------- Stage 3: round, saturate and pack ----------------
    logic        v3_reg;
    logic [63:0] res3_reg;
    logic        ok3_reg, inv3_reg;

    logic [63:0] res3_next, lim, limv, wmask;
    logic        inv3_next, rup, ovf;
    logic [24:0] r32;
    logic [53:0] r64;
    logic [63:0] kept, sub_q;
    logic [7:0]  e32;
    logic [10:0] e64;
    logic signed [12:0] be;
    logic [6:0]  sh;
    logic [63:0] rem_mask, rem, half;

    always_comb begin
        res3_next = direct2_reg;
        inv3_next = 1'b0;
        r32   = 25'd0;
        r64   = 54'd0;
        kept  = 64'd0;
        e32   = 8'd0;
        e64   = 11'd0;
        rup   = 1'b0;
        ovf   = 1'b0;
        be    = 13'sd0;
        sh    = 7'd0;
        rem_mask = 64'd0;
        rem   = 64'd0;
        half  = 64'd0;
        sub_q = 64'd0;
        lim   = dst32_2_reg ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
        wmask = dst32_2_reg ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
        limv  = (sign2_reg ? lim : lim - 64'd1) & wmask;
        unique case (op2_reg)
            OP_DIRECT: begin
                res3_next = direct2_reg;
            end
            OP_I2F: begin
                if (mag2_reg == 64'd0) begin
                    res3_next = 64'd0;
                end else if (dst32_2_reg) begin
                    // 24 kept bits, guard at bit 39, sticky below.
                    rup = mag2_reg[39] && ((mag2_reg[38:0] != 39'd0) || mag2_reg[40]);
                    r32 = {1'b0, mag2_reg[63:40]} + {24'd0, rup};
                    e32 = 8'(p2_reg) + 8'd127 + 8'(r32[24]);
                    res3_next = {32'd0, sign2_reg, e32,
                                 r32[24] ? r32[23:1] : r32[22:0]};
                end else begin
                    rup = mag2_reg[10] && ((mag2_reg[9:0] != 10'd0) || mag2_reg[11]);
                    r64 = {1'b0, mag2_reg[63:11]} + {53'd0, rup};
                    e64 = 11'(p2_reg) + 11'd1023 + 11'(r64[53]);
                    res3_next = {sign2_reg, e64, r64[53] ? r64[52:1] : r64[51:0]};
                end
            end
            OP_F2I: begin
                if (nan2_reg) begin
                    inv3_next = 1'b1;
                    res3_next = 64'd0;
                end else if (inf2_reg || big2_reg) begin
                    inv3_next = 1'b1;
                    res3_next = limv;
                end else if (zero2_reg || exp2_reg < 13'sd0) begin
                    res3_next = 64'd0;
                end else begin
                    ovf = sign2_reg ? (int2_reg > lim) : (int2_reg > lim - 64'd1);
                    if (ovf) begin
                        inv3_next = 1'b1;
                        res3_next = limv;
                    end else begin
                        res3_next = (sign2_reg ? (64'd0 - int2_reg) : int2_reg) & wmask;
                    end
                end
            end
            OP_F2F64: begin
                if (nan2_reg || inf2_reg) begin
                    // A NaN keeps its fraction and gets the quiet bit set.
                    res3_next = {sign2_reg, 11'h7FF, nan2_reg | sig2_reg[51],
                                 sig2_reg[50:0]};
                end else if (zero2_reg) begin
                    if (mag2_reg == 64'd0) begin
                        res3_next = {sign2_reg, 63'd0};
                    end else begin
                        // Subnormal: normalized mantissa sits below bit 63 of mag2.
                        e64 = 11'(p2_reg) + 11'd874;
                        res3_next = {sign2_reg, e64, mag2_reg[62:11]};
                    end
                end else begin
                    e64 = 11'(exp2_reg + 13'sd1023);
                    res3_next = {sign2_reg, e64, sig2_reg[51:0]};
                end
            end
            OP_F2F32: begin
                be = exp2_reg + 13'sd127;
                if (nan2_reg) begin
                    res3_next = {32'd0, sign2_reg, 8'hFF, 1'b1, sig2_reg[50:29]};
                end else if (inf2_reg) begin
                    res3_next = {32'd0, sign2_reg, 8'hFF, 23'd0};
                end else if (zero2_reg || be < -13'sd30) begin
                    res3_next = {32'd0, sign2_reg, 31'd0};
                end else if (be >= 13'sd255) begin
                    res3_next = {32'd0, sign2_reg, 8'hFF, 23'd0};
                end else if (be >= 13'sd1) begin
                    rup = sig2_reg[28] && ((sig2_reg[27:0] != 28'd0) || sig2_reg[29]);
                    r32 = {1'b0, sig2_reg[52:29]} + {24'd0, rup};
                    be  = be + 13'(r32[24]);
                    if (be >= 13'sd255) begin
                        res3_next = {32'd0, sign2_reg, 8'hFF, 23'd0};
                    end else begin
                        res3_next = {32'd0, sign2_reg, 8'(be),
                                     r32[24] ? r32[23:1] : r32[22:0]};
                    end
                end else begin
                    // Subnormal result: shift 30 to 60 with round to nearest even.
                    sh       = 7'(13'sd30 - be);
                    sub_q    = sig2_reg >> sh;
                    rem_mask = (64'd1 << sh) - 64'd1;
                    rem      = sig2_reg & rem_mask;
                    half     = 64'd1 << (sh - 7'd1);
                    if (rem > half || (rem == half && sub_q[0])) begin
                        sub_q = sub_q + 64'd1;
                    end
                    res3_next = {32'd0, sign2_reg, sub_q[30:0]};
                end
            end
            default: begin
                res3_next = direct2_reg;
            end
        endcase
        kept = res3_next;
        res3_next = kept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res3_reg <= ok2_reg ? res3_next : 64'd0;
            ok3_reg  <= ok2_reg;
            inv3_reg <= ok2_reg & inv3_next;
        end
    end

    assign out_valid   = v3_reg;
    assign out_result  = res3_reg;
    assign out_ok      = ok3_reg;
    assign out_invalid = inv3_reg;

endmodule
`default_nettype wire
